### src/u8dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_pkg
// shared types and constants of the utf-8 to code point decoder
// ----------------------------------------------------------------------------

package u8dec_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_CODE       = 2'd0,
        ST_BAD        = 2'd1,
        ST_INCOMPLETE = 2'd2,
        ST_END        = 2'd3
    } t_status;

    localparam logic [31:0] BOM_VALUE     = 32'h0000_FEFF;
    localparam logic [15:0] ERR_POS_MAX   = 16'hFFFF;
    localparam int          CFG_DATA_BITS = 32;
    localparam int          CFG_ADDR_BITS = 3;
    // register index of allow_incomplete_end
    localparam logic        REG_ALLOW_INCOMPLETE = 1'b0;

    // decode state carried from byte to byte
    typedef struct packed {
        logic        discarding;
        logic [2:0]  bytes_pending;
        logic [31:0] value_acc;
    } t_dec_state;

    // one result word
    typedef struct packed {
        logic [31:0] code_point;
        t_status     status;
        logic [15:0] error_position;
        logic        end_of_string;
    } t_result;

endpackage

### src/utf8_to_code_point_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_top
// streaming utf-8 decoder, one byte in, at most one code point word out
// ----------------------------------------------------------------------------
// Takes one byte per cycle and sustains one byte per clock: the decode of a
// byte is a single pass of shallow logic from the held decode state and the
// incoming byte into the result register, so every byte is accepted in the
// cycle it is offered as long as the two-entry output stage (result register
// plus skid register) is not full. A result is registered in the result or
// skid register. Lead bytes announce one to six follow-up bytes; values are
// kept to the low 32 bits. Bad bytes give status 1 with the byte position and
// the rest of the string is dropped; a decoded 0xfeff is dropped; the byte
// flagged last always yields a word with o_end_of_string set. Register 0
// (allow_incomplete_end, bit 0) picks partial value or incomplete error for a
// string cut short; write it only while the block is idle.
// ----------------------------------------------------------------------------

module utf8_to_code_point_decoder_top #(
    parameter int POSITION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // byte input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_byte_in,
    input  logic                                i_last_byte,

    // result output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [31:0]                         o_code_point,
    output logic [1:0]                          o_status,
    output logic [15:0]                         o_error_position,
    output logic                                o_end_of_string,

    // register port
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [u8dec_pkg::CFG_ADDR_BITS-1:0] i_paddr,
    input  logic [u8dec_pkg::CFG_DATA_BITS-1:0] i_pwdata,
    output logic [u8dec_pkg::CFG_DATA_BITS-1:0] o_prdata,
    output logic                                o_pready
);

    // configuration
    logic                     r_allow_incomplete_end;
    logic                     cfg_wr;
    logic                     cfg_sel0;

    // decode state
    u8dec_pkg::t_dec_state    r_state;
    u8dec_pkg::t_dec_state    n_state;
    logic [POSITION_BITS-1:0] r_byte_index;
    logic [POSITION_BITS-1:0] n_byte_index;

    // output stage: result register and skid register
    u8dec_pkg::t_result       r_out;
    logic                     r_out_valid;
    u8dec_pkg::t_result       r_skid;
    logic                     r_skid_valid;

    logic                     in_fire;
    logic                     out_fire;
    logic                     res_valid;
    u8dec_pkg::t_result       res;

    // register access, byte address 4*index
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel & i_penable & i_pwrite;
    assign cfg_sel0 = (i_paddr[2] == u8dec_pkg::REG_ALLOW_INCOMPLETE);
    assign o_prdata = cfg_sel0 ?
                      u8dec_pkg::CFG_DATA_BITS'(r_allow_incomplete_end) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_incomplete_end <= 1'b0;
        end else if (cfg_wr && cfg_sel0) begin
            r_allow_incomplete_end <= i_pwdata[0];
        end
    end

    // input side stalls only while the skid register holds a word
    assign o_ready  = !r_skid_valid;
    assign in_fire  = i_valid & o_ready;
    assign out_fire = r_out_valid & i_ready;

    u8dec_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .i_byte_in              (i_byte_in),
        .i_last_byte            (i_last_byte),
        .i_allow_incomplete_end (r_allow_incomplete_end),
        .i_state                (r_state),
        .i_byte_index           (r_byte_index),
        .o_state                (n_state),
        .o_byte_index           (n_byte_index),
        .o_res_valid            (res_valid),
        .o_res                  (res)
    );

    // decode state moves only on an accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_byte_index <= '0;
        end else if (in_fire) begin
            r_state      <= n_state;
            r_byte_index <= n_byte_index;
        end
    end

    // output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // no byte taken here; drain skid when the word goes out
                if (out_fire) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire && res_valid) begin
                if (r_out_valid && !i_ready) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output stage data
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire && res_valid) begin
            if (r_out_valid && !i_ready) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_code_point     = r_out.code_point;
    assign o_status         = r_out.status;
    assign o_error_position = r_out.error_position;
    assign o_end_of_string  = r_out.end_of_string;

endmodule

### src/u8dec_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8dec_step
// per-byte decode logic: next state and the result word of one byte
// ----------------------------------------------------------------------------

module u8dec_step #(
    parameter int POSITION_BITS = 16
) (
    input  logic [7:0]                i_byte_in,
    input  logic                      i_last_byte,
    input  logic                      i_allow_incomplete_end,
    input  u8dec_pkg::t_dec_state     i_state,
    input  logic [POSITION_BITS-1:0]  i_byte_index,
    output u8dec_pkg::t_dec_state     o_state,
    output logic [POSITION_BITS-1:0]  o_byte_index,
    output logic                      o_res_valid,
    output u8dec_pkg::t_result        o_res
);

    localparam logic [POSITION_BITS-1:0] INDEX_MAX = '1;

    logic [POSITION_BITS-1:0] index_inc;
    logic [15:0]              pos_clip;
    logic [15:0]              end_clip;
    logic [31:0]              pos_ext;
    logic [31:0]              end_ext;
    logic                     have;
    u8dec_pkg::t_dec_state    st;

    // saturating index of the following byte
    assign index_inc = (i_byte_index != INDEX_MAX) ?
                       i_byte_index + POSITION_BITS'(1) : i_byte_index;

    assign pos_ext  = 32'(i_byte_index);
    assign end_ext  = 32'(index_inc);
    assign pos_clip = (pos_ext > 32'(u8dec_pkg::ERR_POS_MAX)) ?
                      u8dec_pkg::ERR_POS_MAX : pos_ext[15:0];
    assign end_clip = (end_ext > 32'(u8dec_pkg::ERR_POS_MAX)) ?
                      u8dec_pkg::ERR_POS_MAX : end_ext[15:0];

    always_comb begin
        st          = i_state;
        have        = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{code_point: 32'd0, status: u8dec_pkg::ST_END,
                        error_position: 16'd0, end_of_string: i_last_byte};

        if (i_state.discarding) begin
            // dropped until end of string
        end else if (i_state.bytes_pending != 3'd0) begin
            if (i_byte_in[7:6] != 2'b10) begin
                o_res_valid          = 1'b1;
                o_res.status         = u8dec_pkg::ST_BAD;
                o_res.error_position = pos_clip;
                st.discarding        = 1'b1;
            end else begin
                st.value_acc     = {i_state.value_acc[25:0], i_byte_in[5:0]};
                st.bytes_pending = i_state.bytes_pending - 3'd1;
                have             = (i_state.bytes_pending == 3'd1);
            end
        end else if (!i_byte_in[7]) begin
            st.value_acc = {24'd0, i_byte_in};
            have         = 1'b1;
        end else if (i_byte_in[7:6] == 2'b10 || i_byte_in == 8'hFF) begin
            o_res_valid          = 1'b1;
            o_res.status         = u8dec_pkg::ST_BAD;
            o_res.error_position = pos_clip;
            st.discarding        = 1'b1;
        end else begin
            // lead byte: count of follow-up bytes from the leading ones
            case (i_byte_in) inside
                8'b110?????: begin
                    st.bytes_pending = 3'd1;
                    st.value_acc     = {27'd0, i_byte_in[4:0]};
                end
                8'b1110????: begin
                    st.bytes_pending = 3'd2;
                    st.value_acc     = {28'd0, i_byte_in[3:0]};
                end
                8'b11110???: begin
                    st.bytes_pending = 3'd3;
                    st.value_acc     = {29'd0, i_byte_in[2:0]};
                end
                8'b111110??: begin
                    st.bytes_pending = 3'd4;
                    st.value_acc     = {30'd0, i_byte_in[1:0]};
                end
                8'b1111110?: begin
                    st.bytes_pending = 3'd5;
                    st.value_acc     = {31'd0, i_byte_in[0]};
                end
                default: begin
                    // 0xfe: six follow-up bytes, no value bits
                    st.bytes_pending = 3'd6;
                    st.value_acc     = 32'd0;
                end
            endcase
        end

        if (have && st.value_acc != u8dec_pkg::BOM_VALUE) begin
            o_res_valid      = 1'b1;
            o_res.status     = u8dec_pkg::ST_CODE;
            o_res.code_point = st.value_acc;
        end

        if (i_last_byte) begin
            if (!o_res_valid) begin
                if (!st.discarding && st.bytes_pending != 3'd0) begin
                    if (i_allow_incomplete_end) begin
                        if (st.value_acc != u8dec_pkg::BOM_VALUE) begin
                            o_res.status     = u8dec_pkg::ST_CODE;
                            o_res.code_point = st.value_acc;
                        end
                    end else begin
                        o_res.status         = u8dec_pkg::ST_INCOMPLETE;
                        o_res.error_position = end_clip;
                    end
                end
                o_res_valid = 1'b1;
            end
        end
    end

    assign o_state      = i_last_byte ? '0 : st;
    assign o_byte_index = i_last_byte ? '0 : index_inc;

endmodule

### tb/sv/tb_utf8_to_code_point_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_code_point_decoder_top
// self-checking bench for the streaming utf-8 to code point decoder
// ----------------------------------------------------------------------------
// Feeds byte words through the valid/ready input and checks every result word
// against typed table rows or a cycle-free decoder written here. A short
// table of hand-picked strings comes first, then random strings built
// mostly from well-formed sequences with faults mixed in. The register is
// flipped between phases while the block is idle. The sender runs in
// bursts with gaps and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------

module tb_utf8_to_code_point_decoder_top;
    import u8dec_pkg::*;

    localparam int unsigned RANDOM_BYTES  = 750;
    localparam int unsigned CFG_EVERY     = 150;     // random bytes between register changes
    localparam int unsigned MAX_GAP       = 8;
    localparam int unsigned MAX_STALL     = 16;
    localparam int unsigned IDLE_CYCLES   = 4;       // settle time before a register write
    localparam int unsigned DRAIN_LIMIT   = 2000;
    localparam int unsigned MAX_BYTES     = 1000;
    localparam int unsigned CYCLE_LIMIT   = MAX_BYTES * (MAX_GAP + MAX_STALL + 4) * 4;
    localparam int unsigned REG_SPARE     = 1;       // unmapped register index

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_HALF,
        SINK_STALLS
    } t_sink_mode;

    // one row of the directed table; the expected word is only used when typed is set
    typedef struct packed {
        logic        set_cfg;
        logic        cfg_val;
        logic [7:0]  b;
        logic        lst;
        logic        typed;
        logic        has;
        t_status     st;
        logic [31:0] cp;
        logic [15:0] pos;
    } t_row;

    localparam int unsigned DIR_ROWS = 28;
    localparam t_row DIR_TABLE [DIR_ROWS] = '{
        // smallest and largest single-byte code points
        '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, ST_CODE, 32'h0000_0000, 16'h0000},
        '{1'b0, 1'b0, 8'h7f, 1'b0, 1'b1, 1'b1, ST_CODE, 32'h0000_007f, 16'h0000},
        // two-byte sequence
        '{1'b0, 1'b0, 8'hc2, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'ha9, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        // byte order mark is swallowed
        '{1'b0, 1'b0, 8'hef, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbb, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbf, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        // 0xfe lead, six follow-ups, value cut to 32 bits, ends the string
        '{1'b0, 1'b0, 8'hfe, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbf, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbf, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbf, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbf, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbf, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbf, 1'b1, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        // lone continuation byte, then the dropped tail ends as end only
        '{1'b0, 1'b0, 8'h80, 1'b0, 1'b1, 1'b1, ST_BAD,  32'h0, 16'h0000},
        '{1'b0, 1'b0, 8'h41, 1'b1, 1'b1, 1'b1, ST_END,  32'h0, 16'h0000},
        // 0xff as the only byte of a string
        '{1'b0, 1'b0, 8'hff, 1'b1, 1'b1, 1'b1, ST_BAD,  32'h0, 16'h0000},
        // follow-up that is not 10xxxxxx
        '{1'b0, 1'b0, 8'hfc, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'h41, 1'b0, 1'b1, 1'b1, ST_BAD,  32'h0, 16'h0001},
        '{1'b0, 1'b0, 8'h80, 1'b1, 1'b1, 1'b1, ST_END,  32'h0, 16'h0000},
        // string cut short, partial value not allowed
        '{1'b0, 1'b0, 8'he0, 1'b1, 1'b1, 1'b1, ST_INCOMPLETE, 32'h0, 16'h0001},
        // partial value allowed from here on
        '{1'b1, 1'b1, 8'he0, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'ha0, 1'b1, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        // partial value equal to the byte order mark gives end only
        '{1'b0, 1'b0, 8'hfc, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'h80, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'h8f, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbb, 1'b0, 1'b0, 1'b0, ST_CODE, 32'h0, 16'h0},
        '{1'b0, 1'b0, 8'hbf, 1'b1, 1'b1, 1'b1, ST_END,  32'h0, 16'h0000}
    };

    // dut signals; the driven ones are known from time zero
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic                     o_ready;
    logic [7:0]               i_byte_in   = 8'h00;
    logic                     i_last_byte = 1'b0;
    logic                     o_valid;
    logic                     i_ready     = 1'b0;
    logic [31:0]              o_code_point;
    logic [1:0]               o_status;
    logic [15:0]              o_error_position;
    logic                     o_end_of_string;
    logic                     i_psel      = 1'b0;
    logic                     i_penable   = 1'b0;
    logic                     i_pwrite    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_paddr     = '0;
    logic [CFG_DATA_BITS-1:0] i_pwdata    = '0;
    logic [CFG_DATA_BITS-1:0] o_prdata;
    logic                     o_pready;

    // decoder mirror
    logic        allow_partial = 1'b0;
    logic [2:0]  seq_left      = '0;
    logic [31:0] seq_value     = '0;
    logic [15:0] str_pos       = '0;
    logic        dropping      = 1'b0;

    // words still owed by the block, oldest first
    t_result     pending_words[$];

    // what the byte on the bus is expected to give when it comes from the table
    logic        row_typed = 1'b0;
    logic        row_has   = 1'b0;
    t_result     row_word;

    int unsigned mismatches    = 0;
    int unsigned words_checked = 0;
    int unsigned bytes_fed     = 0;
    int unsigned strings_fed   = 0;
    int unsigned bytes_queued  = 0;
    int unsigned reg_writes    = 0;
    int unsigned cycle_count   = 0;
    int unsigned burst_left    = 0;
    int unsigned sink_left     = 0;
    int unsigned stall_left    = 0;
    t_sink_mode  sink_mode     = SINK_OPEN;

    utf8_to_code_point_decoder_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_byte_in        (i_byte_in),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_code_point     (o_code_point),
        .o_status         (o_status),
        .o_error_position (o_error_position),
        .o_end_of_string  (o_end_of_string),
        .i_psel           (i_psel),
        .i_penable        (i_penable),
        .i_pwrite         (i_pwrite),
        .i_paddr          (i_paddr),
        .i_pwdata         (i_pwdata),
        .o_prdata         (o_prdata),
        .o_pready         (o_pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed",
                     cycle_count, pending_words.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_result make_word(input logic [31:0] cp, input t_status st,
                                          input logic [15:0] pos, input logic eos);
        t_result w;
        w.code_point     = cp;
        w.status         = st;
        w.error_position = pos;
        w.end_of_string  = eos;
        return w;
    endfunction

    // advances the mirror by one byte; returns 1 when the byte yields a word
    function automatic logic decode_byte(input logic [7:0] b, input logic lst,
                                         output t_result w);
        logic [15:0] at;
        logic        have;
        logic        made;
        int unsigned lead_ones;
        at   = str_pos;
        have = 1'b0;
        made = 1'b0;
        w    = make_word(32'h0, ST_CODE, 16'h0, lst);
        if (str_pos != 16'hffff)
            str_pos = str_pos + 16'd1;

        if (dropping) begin
            // rest of the string is thrown away
        end else if (seq_left != 3'd0) begin
            if (b[7:6] != 2'b10) begin
                w        = make_word(32'h0, ST_BAD, at, lst);
                made     = 1'b1;
                dropping = 1'b1;
            end else begin
                seq_value = {seq_value[25:0], b[5:0]};
                seq_left  = seq_left - 3'd1;
                have      = (seq_left == 3'd0);
            end
        end else if (!b[7]) begin
            seq_value = {24'h0, b};
            have      = 1'b1;
        end else if (b[7:6] == 2'b10 || b == 8'hff) begin
            w        = make_word(32'h0, ST_BAD, at, lst);
            made     = 1'b1;
            dropping = 1'b1;
        end else begin
            // count the ones below the top bit, at most six
            lead_ones = 0;
            while (lead_ones < 6 && b[6 - lead_ones])
                lead_ones++;
            seq_left  = 3'(lead_ones);
            seq_value = {24'h0, b & (8'h3f >> lead_ones)};
        end

        if (have && seq_value != BOM_VALUE) begin
            w    = make_word(seq_value, ST_CODE, 16'h0, lst);
            made = 1'b1;
        end

        if (lst) begin
            if (!made) begin
                if (!dropping && seq_left != 3'd0) begin
                    if (!allow_partial)
                        w = make_word(32'h0, ST_INCOMPLETE,
                                      (at != 16'hffff) ? at + 16'd1 : at, 1'b1);
                    else if (seq_value != BOM_VALUE)
                        w = make_word(seq_value, ST_CODE, 16'h0, 1'b1);
                    else
                        w = make_word(32'h0, ST_END, 16'h0, 1'b1);
                end else begin
                    w = make_word(32'h0, ST_END, 16'h0, 1'b1);
                end
                made = 1'b1;
            end
            seq_left  = '0;
            seq_value = '0;
            str_pos   = '0;
            dropping  = 1'b0;
        end
        return made;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] word %0d %s: got 0x%0h, want 0x%0h",
                 $time, words_checked, what, got, want);
    endtask

    // adds a word to the tail of the owed list
    task automatic owe_word(input t_result w);
        pending_words.insert(pending_words.size(), w);
    endtask

    // scoreboard: check the word leaving the block, then queue what the accepted byte owes
    always @(posedge i_clk) begin
        t_result oldest;
        t_result fresh;
        logic    made;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("arrived with nothing owed", o_code_point, 32'h0);
                end else begin
                    oldest = pending_words.pop_front();
                    if (o_code_point !== oldest.code_point)
                        report_mismatch("code_point", o_code_point, oldest.code_point);
                    if (o_status !== oldest.status)
                        report_mismatch("status", 32'(o_status), 32'(oldest.status));
                    if (o_error_position !== oldest.error_position)
                        report_mismatch("error_position", 32'(o_error_position),
                                        32'(oldest.error_position));
                    if (o_end_of_string !== oldest.end_of_string)
                        report_mismatch("end_of_string", 32'(o_end_of_string),
                                        32'(oldest.end_of_string));
                end
                words_checked++;
            end
            if (i_valid && o_ready) begin
                made = decode_byte(i_byte_in, i_last_byte, fresh);
                if (row_typed) begin
                    if (row_has)
                        owe_word(row_word);
                end else if (made) begin
                    owe_word(fresh);
                end
                bytes_fed++;
                if (i_last_byte)
                    strings_fed++;
            end
        end
    end

    // receiver: switches between open, light, half and long-stall patterns
    always @(negedge i_clk) begin
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_left = $urandom_range(20, 200);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN:  i_ready <= 1'b1;
            SINK_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
            SINK_HALF:  i_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_left != 0) begin
                    stall_left--;
                    i_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, MAX_STALL - 1);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    // one byte word on the input, with a random gap whenever a burst runs out
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                             input logic has, input t_result word);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap != 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_byte_in   <= b;
        i_last_byte <= lst;
        row_typed = typed;
        row_has   = has;
        row_word  = word;
        do @(posedge i_clk); while (!o_ready);
        bytes_queued++;
    endtask

    // setup cycle, access cycle; pready is waited on even though it should stay high
    task automatic reg_access(input logic wr, input int unsigned idx,
                              input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= CFG_ADDR_BITS'(4 * idx);
        i_pwdata  <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (wr) begin
            if (idx == REG_ALLOW_INCOMPLETE)
                allow_partial = data[0];
            reg_writes++;
        end else if (o_prdata !== {{(CFG_DATA_BITS-1){1'b0}}, allow_partial}) begin
            report_mismatch("register read", o_prdata, 32'(allow_partial));
        end
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    // drop valid, wait for every owed word, then let the pipe settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    // new mode with junk in the unused bits, a write to the unmapped slot, then read back
    task automatic set_allow(input logic v);
        logic [CFG_DATA_BITS-1:0] data;
        wait_idle();
        data    = $urandom();
        data[0] = v;
        reg_access(1'b1, REG_ALLOW_INCOMPLETE, data);
        reg_access(1'b1, REG_SPARE, $urandom());
        reg_access(1'b0, REG_ALLOW_INCOMPLETE, '0);
    endtask

    // random string, mostly well-formed; faulty strings also get bad leads,
    // broken follow-ups and an early end
    task automatic send_random_string();
        logic [7:0]  str[$];
        logic [7:0]  b;
        logic        clean;
        logic        cut;
        int unsigned chars;
        int unsigned kind;
        int unsigned follow;
        int unsigned keep;
        t_result     none;
        chars = $urandom_range(1, 10);
        clean = ($urandom_range(0, 9) < 7);
        cut   = 1'b0;
        none  = make_word(32'h0, ST_CODE, 16'h0, 1'b0);
        for (int c = 0; c < chars && !cut; c++) begin
            kind = clean ? $urandom_range(0, 78) : $urandom_range(0, 99);
            if (kind < 30) begin
                str.insert(str.size(), 8'($urandom_range(0, 127)));
            end else if (kind < 74) begin
                if (kind < 45)      follow = 1;
                else if (kind < 57) follow = 2;
                else if (kind < 65) follow = 3;
                else if (kind < 69) follow = 4;
                else if (kind < 72) follow = 5;
                else                follow = 6;
                str.insert(str.size(),
                           ~(8'hff >> (follow + 1)) | (8'($urandom) & (8'h3f >> follow)));
                repeat (follow) str.insert(str.size(), {2'b10, 6'($urandom)});
            end else if (kind < 79) begin
                str.insert(str.size(), 8'hef);
                str.insert(str.size(), 8'hbb);
                str.insert(str.size(), 8'hbf);
            end else if (kind < 85) begin
                str.insert(str.size(), {2'b10, 6'($urandom)});
            end else if (kind < 88) begin
                str.insert(str.size(), 8'hff);
            end else begin
                // sequence left open: broken by a stray byte or by the end of the string
                follow = $urandom_range(1, 6);
                keep   = $urandom_range(0, follow - 1);
                str.insert(str.size(),
                           ~(8'hff >> (follow + 1)) | (8'($urandom) & (8'h3f >> follow)));
                repeat (keep) str.insert(str.size(), {2'b10, 6'($urandom)});
                if (kind < 96) begin
                    b = 8'($urandom);
                    if (b[7:6] == 2'b10)
                        b[6] = 1'b1;
                    str.insert(str.size(), b);
                end else begin
                    cut = 1'b1;
                end
            end
        end
        foreach (str[i])
            send_byte(str[i], (i == str.size() - 1), 1'b0, 1'b0, none);
    endtask

    initial begin
        int unsigned next_cfg;
        int unsigned drain;
        t_row        r;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register must come out of reset cleared
        reg_access(1'b0, REG_ALLOW_INCOMPLETE, '0);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            r = DIR_TABLE[i];
            if (r.set_cfg)
                set_allow(r.cfg_val);
            send_byte(r.b, r.lst, r.typed, r.has, make_word(r.cp, r.st, r.pos, r.lst));
        end

        // random strings, flipping the mode between phases
        next_cfg = bytes_queued + CFG_EVERY;
        set_allow(1'b0);
        while (bytes_queued < DIR_ROWS + RANDOM_BYTES) begin
            if (bytes_queued >= next_cfg) begin
                set_allow(!allow_partial);
                next_cfg = bytes_queued + CFG_EVERY;
            end
            send_random_string();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain = 0;
        while (pending_words.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (IDLE_CYCLES * 2) @(posedge i_clk);
        if (pending_words.size() != 0)
            report_mismatch("words never delivered", 32'(pending_words.size()), 32'h0);

        $display("fed %0d bytes in %0d strings, checked %0d result words",
                 bytes_fed, strings_fed, words_checked);
        $display("%0d register writes, both end modes, bursty sender, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### utf8_to_code_point_decoder_top.f
src/u8dec_pkg.sv
src/u8dec_step.sv
src/utf8_to_code_point_decoder_top.sv
tb/sv/tb_utf8_to_code_point_decoder_top.sv
